>>> rtl/core/rde_pkg.sv
package rde_pkg;

	localparam int unsigned RAM_BYTES = 524288;
	localparam int unsigned RAM_AW    = $clog2(RAM_BYTES);
	localparam int unsigned XADDR_W   = 24;
	localparam int unsigned REM_W     = 17;
	localparam logic [REM_W-1:0] LEN_FULL = REM_W'(17'h10000);

	typedef enum logic [1:0] {
		ACT_READ  = 2'd0,
		ACT_WRITE = 2'd1,
		ACT_BEAT  = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		XF_TO_RAM  = 2'd0,
		XF_TO_HOST = 2'd1,
		XF_SWAP    = 2'd2,
		XF_VERIFY  = 2'd3
	} xfer_type_t;

	typedef enum logic [3:0] {
		REG_STATUS    = 4'd0,
		REG_COMMAND   = 4'd1,
		REG_HOST_LO   = 4'd2,
		REG_HOST_HI   = 4'd3,
		REG_EXP_LO    = 4'd4,
		REG_EXP_HI    = 4'd5,
		REG_EXP_BANK  = 4'd6,
		REG_LEN_LO    = 4'd7,
		REG_LEN_HI    = 4'd8,
		REG_IRQ_MASK  = 4'd9,
		REG_ADDR_CTRL = 4'd10
	} reg_offset_t;

	typedef enum logic {
		CFG_DEVICE_EN = 1'b0,
		CFG_SIZE_FLAG = 1'b1
	} cfg_index_t;

	// status flag bits
	localparam int unsigned FL_IRQ  = 2;
	localparam int unsigned FL_EOB  = 1;
	localparam int unsigned FL_VERR = 0;

	typedef struct packed {
		logic [1:0] action;
		logic [3:0] reg_offset;
		logic [7:0] write_data;
		logic [7:0] host_data;
	} in_word_t;

	typedef struct packed {
		logic [7:0]  read_data;
		logic        busy_res;
		logic [15:0] host_next_address;
		logic        host_write_enable;
		logic [15:0] host_write_address;
		logic [7:0]  host_write_data;
		logic        irq_line;
	} out_word_t;

endpackage

>>> rtl/core/rde_in_if.sv
interface rde_in_if;
	logic             valid;
	logic             ready;
	rde_pkg::in_word_t word;

	modport source(output valid, output word, input ready);
	modport sink(input valid, input word, output ready);
endinterface

>>> rtl/core/rde_out_if.sv
interface rde_out_if;
	logic               valid;
	logic               ready;
	rde_pkg::out_word_t word;

	modport source(output valid, output word, input ready);
	modport sink(input valid, input word, output ready);
endinterface

>>> rtl/core/ram_expansion_dma_controller.sv
// channel   dir  handshake      word
// in_ch     in   valid/ready    action, reg_offset, write_data, host_data
// out_ch    out  valid/ready    read_data, busy_res, host addresses/data, irq_line
// cfg       in   cfg_we         cfg_index, cfg_wdata (no handshake)
//
// one word per cycle sustained while the output is not stalled; a word in the execute stage
// uses the registered expansion ram read, then sits in the output register
// ram read address for the next word comes from the executing word's next state
// after reset a clearing pass zeroes the ram, with in_ch.ready low until it ends
// a stalled output holds the execute stage, which then holds the input
module ram_expansion_dma_controller (
	input  logic        clk,
	input  logic        arst_n,
	rde_in_if.sink      in_ch,
	rde_out_if.source   out_ch,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic        cfg_wdata
);

	localparam int unsigned AW = rde_pkg::RAM_AW;

	// config
	logic dev_en_q;
	logic size_flag_q;

	// register file
	logic [2:0]                   flags_q, nxt_flags;
	logic [7:0]                   cmd_q, nxt_cmd;
	logic [15:0]                  host_addr_q, nxt_host_addr;
	logic [15:0]                  exp_lo_q, nxt_exp_lo;
	logic [7:0]                   bank_q, nxt_bank;
	logic [15:0]                  len_q, nxt_len;
	logic [7:0]                   irq_mask_q, nxt_irq_mask;
	logic [7:0]                   addr_ctrl_q, nxt_addr_ctrl;
	logic [rde_pkg::REM_W-1:0]    bytes_rem_q, nxt_bytes_rem;
	logic                         active_q, nxt_active;

	// pipeline
	logic               s1_valid_q;
	rde_pkg::in_word_t  s1_q;
	logic               out_valid_q;
	rde_pkg::out_word_t out_q;
	rde_pkg::out_word_t res;
	logic               s1_fire;
	logic               accept;

	// ram
	logic [7:0]    mem [rde_pkg::RAM_BYTES];
	logic [7:0]    ram_rd_q;
	logic          fwd_q;
	logic [7:0]    fwd_data_q;
	logic [7:0]    ram_val;
	logic          ram_we_c;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] rd_addr;
	logic          clr_busy_q;
	logic [AW-1:0] clr_cnt_q;

	logic [rde_pkg::XADDR_W-1:0] exp_addr;
	logic [rde_pkg::XADDR_W-1:0] nxt_exp_addr;
	logic [rde_pkg::XADDR_W-1:0] exp_inc;
	logic                        mism;
	logic [7:0]                  wd;

	function automatic logic [2:0] irq_calc(input logic [7:0] mask, input logic [2:0] fl);
		logic [2:0] f;
		f = fl;
		f[rde_pkg::FL_IRQ] = mask[7] && ((mask[6] && fl[rde_pkg::FL_EOB]) ||
			(mask[5] && fl[rde_pkg::FL_VERR]));
		return f;
	endfunction

	assign s1_fire     = s1_valid_q && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = !clr_busy_q && (!s1_valid_q || s1_fire);
	assign accept      = in_ch.valid && in_ch.ready;
	assign out_ch.valid = out_valid_q;
	assign out_ch.word  = out_q;

	assign ram_val  = fwd_q ? fwd_data_q : ram_rd_q;
	assign exp_addr = {bank_q, exp_lo_q};
	assign exp_inc  = exp_addr + rde_pkg::XADDR_W'(1);
	assign wd       = s1_q.write_data;

	// execute stage: next register state and result word
	always_comb begin
		nxt_flags     = flags_q;
		nxt_cmd       = cmd_q;
		nxt_host_addr = host_addr_q;
		nxt_exp_lo    = exp_lo_q;
		nxt_bank      = bank_q;
		nxt_len       = len_q;
		nxt_irq_mask  = irq_mask_q;
		nxt_addr_ctrl = addr_ctrl_q;
		nxt_bytes_rem = bytes_rem_q;
		nxt_active    = active_q;
		ram_we_c      = 1'b0;
		mism          = 1'b0;
		res           = '0;
		res.read_data = 8'hFF;
		case (s1_q.action)
			rde_pkg::ACT_READ: begin
				if (!active_q) begin
					unique case (s1_q.reg_offset)
						rde_pkg::REG_STATUS: res.read_data = {flags_q, 5'd0} |
							(dev_en_q ? {3'd0, size_flag_q, 3'd0, 1'b1} : 8'd0);
						rde_pkg::REG_COMMAND:   res.read_data = cmd_q;
						rde_pkg::REG_HOST_LO:   res.read_data = host_addr_q[7:0];
						rde_pkg::REG_HOST_HI:   res.read_data = host_addr_q[15:8];
						rde_pkg::REG_EXP_LO:    res.read_data = exp_lo_q[7:0];
						rde_pkg::REG_EXP_HI:    res.read_data = exp_lo_q[15:8];
						rde_pkg::REG_EXP_BANK:  res.read_data = bank_q;
						rde_pkg::REG_LEN_LO:    res.read_data = len_q[7:0];
						rde_pkg::REG_LEN_HI:    res.read_data = len_q[15:8];
						rde_pkg::REG_IRQ_MASK:  res.read_data = irq_mask_q | 8'h1F;
						rde_pkg::REG_ADDR_CTRL: res.read_data = addr_ctrl_q | 8'h3F;
						default:                res.read_data = 8'hFF;
					endcase
				end
			end
			rde_pkg::ACT_WRITE: begin
				if (!active_q) begin
					unique case (s1_q.reg_offset)
						rde_pkg::REG_STATUS:
							nxt_flags = irq_calc(irq_mask_q, flags_q & ~wd[7:5]);
						rde_pkg::REG_COMMAND: begin
							nxt_cmd = wd;
							if (wd[7] && dev_en_q) begin
								nxt_flags     = '0;
								nxt_bytes_rem = (len_q == 16'd0) ? rde_pkg::LEN_FULL :
									{1'b0, len_q};
								nxt_active    = 1'b1;
							end
						end
						rde_pkg::REG_HOST_LO:   nxt_host_addr[7:0]  = wd;
						rde_pkg::REG_HOST_HI:   nxt_host_addr[15:8] = wd;
						rde_pkg::REG_EXP_LO:    nxt_exp_lo[7:0]     = wd;
						rde_pkg::REG_EXP_HI:    nxt_exp_lo[15:8]    = wd;
						rde_pkg::REG_EXP_BANK:  nxt_bank            = wd;
						rde_pkg::REG_LEN_LO:    nxt_len[7:0]        = wd;
						rde_pkg::REG_LEN_HI:    nxt_len[15:8]       = wd;
						rde_pkg::REG_IRQ_MASK: begin
							nxt_irq_mask = wd;
							nxt_flags    = irq_calc(wd, flags_q);
						end
						rde_pkg::REG_ADDR_CTRL: nxt_addr_ctrl = wd;
						default: ;
					endcase
				end
			end
			rde_pkg::ACT_BEAT: begin
				if (active_q) begin
					case (cmd_q[1:0])
						rde_pkg::XF_TO_RAM: ram_we_c = 1'b1;
						rde_pkg::XF_TO_HOST: begin
							res.host_write_enable  = 1'b1;
							res.host_write_address = host_addr_q;
							res.host_write_data    = ram_val;
						end
						rde_pkg::XF_SWAP: begin
							ram_we_c               = 1'b1;
							res.host_write_enable  = 1'b1;
							res.host_write_address = host_addr_q;
							res.host_write_data    = ram_val;
						end
						default: mism = (s1_q.host_data != ram_val);
					endcase
					if (mism) begin
						nxt_flags     = irq_calc(irq_mask_q, flags_q | 3'b011);
						nxt_active    = 1'b0;
						nxt_bytes_rem = '0;
					end else begin
						if (!addr_ctrl_q[7])
							nxt_host_addr = host_addr_q + 16'd1;
						if (!addr_ctrl_q[6]) begin
							nxt_exp_lo = exp_inc[15:0];
							nxt_bank   = exp_inc[23:16];
						end
						nxt_bytes_rem = bytes_rem_q - rde_pkg::REM_W'(1);
						if (nxt_bytes_rem == '0) begin
							nxt_active = 1'b0;
							nxt_flags  = irq_calc(irq_mask_q,
								flags_q | (3'b001 << rde_pkg::FL_EOB));
						end
					end
				end
			end
			default: ;
		endcase
		res.busy_res          = nxt_active;
		res.host_next_address = nxt_host_addr;
		res.irq_line          = nxt_flags[rde_pkg::FL_IRQ];
	end

	assign wr_en        = s1_fire && ram_we_c;
	assign wr_addr      = exp_addr[AW-1:0];
	assign nxt_exp_addr = {nxt_bank, nxt_exp_lo};
	// next word reads at the address left by the executing word
	assign rd_addr = s1_valid_q ? nxt_exp_addr[AW-1:0] : exp_addr[AW-1:0];

	always_ff @(posedge clk) begin
		if (clr_busy_q)
			mem[clr_cnt_q] <= 8'd0;
		else if (wr_en)
			mem[wr_addr] <= s1_q.host_data;
		if (accept) begin
			ram_rd_q   <= mem[rd_addr];
			fwd_q      <= wr_en && (wr_addr == rd_addr);
			fwd_data_q <= s1_q.host_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clr_busy_q) begin
			clr_cnt_q <= clr_cnt_q + AW'(1);
			if (clr_cnt_q == AW'(rde_pkg::RAM_BYTES - 1))
				clr_busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_en_q    <= 1'b1;
			size_flag_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rde_pkg::CFG_DEVICE_EN: dev_en_q    <= cfg_wdata;
				rde_pkg::CFG_SIZE_FLAG: size_flag_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q     <= '0;
			cmd_q       <= '0;
			host_addr_q <= '0;
			exp_lo_q    <= '0;
			bank_q      <= '0;
			len_q       <= '0;
			irq_mask_q  <= '0;
			addr_ctrl_q <= '0;
			bytes_rem_q <= '0;
			active_q    <= 1'b0;
		end else if (s1_fire) begin
			flags_q     <= nxt_flags;
			cmd_q       <= nxt_cmd;
			host_addr_q <= nxt_host_addr;
			exp_lo_q    <= nxt_exp_lo;
			bank_q      <= nxt_bank;
			len_q       <= nxt_len;
			irq_mask_q  <= nxt_irq_mask;
			addr_ctrl_q <= nxt_addr_ctrl;
			bytes_rem_q <= nxt_bytes_rem;
			active_q    <= nxt_active;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept)
				s1_valid_q <= 1'b1;
			else if (s1_fire)
				s1_valid_q <= 1'b0;
			if (s1_fire)
				out_valid_q <= 1'b1;
			else if (out_ch.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			s1_q <= in_ch.word;
		if (s1_fire)
			out_q <= res;
	end

	a_clear_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !in_ch.ready)
		else $error("word accepted during ram clearing pass");

	a_active_has_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (bytes_rem_q != '0))
		else $error("transfer active with no bytes left");

	a_irq_needs_enable: assert property (@(posedge clk) disable iff (!arst_n)
		flags_q[rde_pkg::FL_IRQ] |-> irq_mask_q[7])
		else $error("irq pending with irq enable clear");

	a_ram_write_on_beat: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (active_q && s1_q.action == rde_pkg::ACT_BEAT))
		else $error("ram written outside an active beat");

endmodule
